>>> hdl/assert_macros.svh
// Assertion macros used by the top level of the draw batch slot binder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

>>> hdl/dbtsb_pkg.sv
// Types and constants shared by the draw batch slot binder modules.
package dbtsb_pkg;

	// Command opcodes
	localparam logic [2:0] OP_BEGIN  = 3'd0;
	localparam logic [2:0] OP_QUAD   = 3'd1;
	localparam logic [2:0] OP_TEX    = 3'd2;
	localparam logic [2:0] OP_CIRCLE = 3'd3;
	localparam logic [2:0] OP_LINE   = 3'd4;
	localparam logic [2:0] OP_END    = 3'd5;
	localparam logic [2:0] OP_RSTAT  = 3'd6;

	// Register indexes (paddr bit 2) and reset values
	localparam logic REG_QUAD_LIMIT = 1'b0;
	localparam logic REG_SLOT_LIMIT = 1'b1;
	localparam logic [13:0] QUAD_LIMIT_RST = 14'd8192;
	localparam logic [5:0]  SLOT_LIMIT_RST = 6'd32;

	// Result kinds
	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	typedef enum logic [2:0] {
		CMD_BEGIN,
		CMD_QUAD,
		CMD_TEX,
		CMD_CIRCLE,
		CMD_LINE,
		CMD_END,
		CMD_RSTAT,
		CMD_NOP
	} cmd_class_t;

	typedef struct packed {
		cmd_class_t  cls;
		logic [31:0] tex;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [13:0] quad_limit;
		logic [5:0]  slot_limit;
	} cfg_t;

	typedef enum logic [1:0] {
		PRIM_QUADS,
		PRIM_CIRCLES,
		PRIM_LINES
	} prim_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CHECK,
		BK_FLUSH,
		BK_SEARCH,
		BK_ACK
	} back_state_t;

endpackage

>>> hdl/draw_batch_texture_slot_binder_top.sv
// Top level of the draw batch texture slot binder: config registers and instances.
// Each request passes the front register and the queue; the back end then checks it, flushes
// the batch over the primitives if needed, searches the slot table for a textured quad (flushing
// again when the table is full) and acknowledges, and result stalls hold every result back.
// A 2-entry queue and a front register hold up to 3 more requests while one is worked on.
// Reset (arst_n low, asynchronous): batch empty, slot fill 1, totals zero, limits 8192, 32.
module draw_batch_texture_slot_binder_top import dbtsb_pkg::*; #(
	parameter int MAX_QUADS = 8192,
	parameter int TEX_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  opcode,
	input  logic [31:0] texture_id,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        kind,
	output logic [1:0]  primitive_res,
	output logic [16:0] draw_count,
	output logic [5:0]  slots_in_use,
	output logic [4:0]  tex_slot,
	output logic        last,
	output logic [31:0] draw_calls_total,
	output logic [31:0] quads_total,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "assert_macros.svh"

	cfg_t    cfg_q;
	q_stat_t q_stat;
	logic    push;
	cmd_t    push_data;
	logic    pop;
	cmd_t    pop_data;
	logic    cfg_wr;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quad_limit <= QUAD_LIMIT_RST;
			cfg_q.slot_limit <= SLOT_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_QUAD_LIMIT: cfg_q.quad_limit <= pwdata[13:0];
				REG_SLOT_LIMIT: cfg_q.slot_limit <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (paddr[2])
			REG_QUAD_LIMIT: prdata = {18'd0, cfg_q.quad_limit};
			REG_SLOT_LIMIT: prdata = {26'd0, cfg_q.slot_limit};
			default:        prdata = 32'd0;
		endcase
	end

	dbtsb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.opcode     (opcode),
		.texture_id (texture_id),
		.q_stat     (q_stat),
		.push       (push),
		.push_data  (push_data)
	);

	dbtsb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	dbtsb_back #(
		.MAX_QUADS (MAX_QUADS),
		.TEX_SLOTS (TEX_SLOTS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_stat           (q_stat),
		.q_data           (pop_data),
		.pop              (pop),
		.res_stall        (res_stall),
		.res_valid        (res_valid),
		.kind             (kind),
		.primitive_res    (primitive_res),
		.draw_count       (draw_count),
		.slots_in_use     (slots_in_use),
		.tex_slot         (tex_slot),
		.last             (last),
		.draw_calls_total (draw_calls_total),
		.quads_total      (quads_total)
	);

	// Queue is never pushed when full nor popped when empty
	`ASSERT_NEVER(a_push_full, push && q_stat.full, "queue pushed while full")
	`ASSERT_NEVER(a_pop_empty, pop && q_stat.empty, "queue popped while empty")
	// Acknowledgements close a command, draw calls never do
	`ASSERT_CLK(a_last_kind, res_valid |-> (kind != last), "last flag disagrees with kind")
	// Draw calls carry no texture slot
	`ASSERT_CLK(a_draw_slot, (res_valid && kind) |-> (tex_slot == 5'd0), "draw call carries a slot")

endmodule

>>> hdl/dbtsb_front.sv
// Front end: accepts command requests, decodes them and pushes them into the queue.
module dbtsb_front import dbtsb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  opcode,
	input  logic [31:0] texture_id,
	input  q_stat_t     q_stat,
	output logic        push,
	output cmd_t        push_data
);

	logic       valid_s1;
	cmd_t       cmd_s1;
	cmd_class_t cls;
	logic       accept;

	// Decode the opcode into a command class
	always_comb begin
		unique case (opcode)
			OP_BEGIN:  cls = CMD_BEGIN;
			OP_QUAD:   cls = CMD_QUAD;
			OP_TEX:    cls = CMD_TEX;
			OP_CIRCLE: cls = CMD_CIRCLE;
			OP_LINE:   cls = CMD_LINE;
			OP_END:    cls = CMD_END;
			OP_RSTAT:  cls = CMD_RSTAT;
			default:   cls = CMD_NOP;
		endcase
	end

	// Hold the request while the queue is full
	assign cmd_stall = valid_s1 && q_stat.full;
	assign accept    = cmd_valid && !cmd_stall;
	assign push      = valid_s1 && !q_stat.full;
	assign push_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.cls <= cls;
			cmd_s1.tex <= texture_id;
		end
	end

endmodule

>>> hdl/dbtsb_queue.sv
// Two-entry command queue between the front end and the back end.
module dbtsb_queue import dbtsb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_data,
	input  logic    pop,
	output cmd_t    pop_data,
	output q_stat_t q_stat
);

	localparam int DEPTH = 2;

	cmd_t       entry_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign pop_data     = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == 2'(DEPTH));
	assign q_stat.empty = (count_q == 2'd0);

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> hdl/dbtsb_back.sv
// Back end: batch counters, slot table, draw call sequencing and result register.
module dbtsb_back import dbtsb_pkg::*; #(
	parameter int MAX_QUADS = 8192,
	parameter int TEX_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  q_stat_t     q_stat,
	input  cmd_t        q_data,
	output logic        pop,
	input  logic        res_stall,
	output logic        res_valid,
	output logic        kind,
	output logic [1:0]  primitive_res,
	output logic [16:0] draw_count,
	output logic [5:0]  slots_in_use,
	output logic [4:0]  tex_slot,
	output logic        last,
	output logic [31:0] draw_calls_total,
	output logic [31:0] quads_total
);

	localparam logic [13:0] QLIM_MAX = 14'(MAX_QUADS);
	localparam logic [5:0]  SLIM_MAX = 6'(TEX_SLOTS);

	back_state_t state_q, state_d;

	cmd_t        cmd_q, cmd_d;
	logic [4:0]  slot_q, slot_d;
	prim_t       flush_idx_q, flush_idx_d;
	logic        flush_clear_q, flush_clear_d;
	logic        ret_search_q, ret_search_d;

	logic [5:0]  slot_fill_q, slot_fill_d;
	logic [13:0] quad_cnt_q, quad_cnt_d;
	logic [13:0] circle_cnt_q, circle_cnt_d;
	logic [15:0] line_cnt_q, line_cnt_d;
	logic [31:0] dcalls_q, dcalls_d;
	logic [31:0] quads_q, quads_d;

	logic [31:0] slot_table_q [1:TEX_SLOTS-1];
	logic        tbl_wr;

	// Result register
	logic        res_valid_q, res_valid_d;
	logic        res_load;
	logic        res_kind_d, res_kind_q;
	logic [1:0]  res_prim_d, res_prim_q;
	logic [16:0] res_cnt_d, res_cnt_q;
	logic [5:0]  res_slots_d, res_slots_q;
	logic [4:0]  res_slot_d, res_slot_q;
	logic        res_last_d, res_last_q;

	logic [13:0] qlim;
	logic [5:0]  slim;
	logic        out_free;
	logic        hit;
	logic [4:0]  hit_idx;
	logic        need_flush;
	logic        fl_nz;
	logic [16:0] fl_cnt;
	logic [5:0]  fl_slots;
	prim_t       fl_next;

	// Saturate the limits to their legal ranges
	always_comb begin
		qlim = cfg.quad_limit;
		if (qlim == 14'd0) begin
			qlim = 14'd1;
		end else if (qlim > QLIM_MAX) begin
			qlim = QLIM_MAX;
		end
		slim = cfg.slot_limit;
		if (slim < 6'd2) begin
			slim = 6'd2;
		end else if (slim > SLIM_MAX) begin
			slim = SLIM_MAX;
		end
	end

	// Compare all bound slots in parallel, lowest match wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = 5'd0;
		for (int i = TEX_SLOTS - 1; i >= 1; i--) begin
			if (6'(i) < slot_fill_q && slot_table_q[i] == cmd_q.tex) begin
				hit     = 1'b1;
				hit_idx = 5'(i);
			end
		end
	end

	// Select the pending draw call of the current flush step
	always_comb begin
		unique case (flush_idx_q)
			PRIM_QUADS: begin
				fl_nz    = (quad_cnt_q != 14'd0);
				fl_cnt   = 17'({quad_cnt_q, 2'b00}) + 17'({quad_cnt_q, 1'b0});
				fl_slots = slot_fill_q;
				fl_next  = PRIM_CIRCLES;
			end
			PRIM_CIRCLES: begin
				fl_nz    = (circle_cnt_q != 14'd0);
				fl_cnt   = 17'({circle_cnt_q, 2'b00}) + 17'({circle_cnt_q, 1'b0});
				fl_slots = 6'd0;
				fl_next  = PRIM_LINES;
			end
			PRIM_LINES: begin
				fl_nz    = (line_cnt_q != 16'd0);
				fl_cnt   = {1'b0, line_cnt_q};
				fl_slots = 6'd0;
				fl_next  = PRIM_QUADS;
			end
			default: begin
				fl_nz    = 1'b0;
				fl_cnt   = 17'd0;
				fl_slots = 6'd0;
				fl_next  = PRIM_QUADS;
			end
		endcase
	end

	// Decide whether the command forces its batch out first
	always_comb begin
		case (cmd_q.cls) inside
			CMD_QUAD, CMD_TEX: need_flush = (quad_cnt_q >= qlim);
			CMD_CIRCLE:        need_flush = (circle_cnt_q >= qlim);
			CMD_LINE:          need_flush = (({1'b0, line_cnt_q} + 17'd2) >
				{1'b0, qlim, 2'b00});
			CMD_END:           need_flush = 1'b1;
			default:           need_flush = 1'b0;
		endcase
	end

	assign out_free = !res_valid_q || !res_stall;

	// Sequence one command: check, flush, slot search, acknowledge
	always_comb begin
		state_d       = state_q;
		cmd_d         = cmd_q;
		slot_d        = slot_q;
		flush_idx_d   = flush_idx_q;
		flush_clear_d = flush_clear_q;
		ret_search_d  = ret_search_q;
		slot_fill_d   = slot_fill_q;
		quad_cnt_d    = quad_cnt_q;
		circle_cnt_d  = circle_cnt_q;
		line_cnt_d    = line_cnt_q;
		dcalls_d      = dcalls_q;
		quads_d       = quads_q;
		pop           = 1'b0;
		tbl_wr        = 1'b0;
		res_load      = 1'b0;
		res_kind_d    = KIND_ACK;
		res_prim_d    = PRIM_QUADS;
		res_cnt_d     = 17'd0;
		res_slots_d   = 6'd0;
		res_slot_d    = 5'd0;
		res_last_d    = 1'b1;
		res_valid_d   = res_valid_q && res_stall;

		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					cmd_d   = q_data;
					state_d = BK_CHECK;
				end
			end
			BK_CHECK: begin
				slot_d = 5'd0;
				if (need_flush) begin
					flush_idx_d   = PRIM_QUADS;
					flush_clear_d = (cmd_q.cls != CMD_END);
					ret_search_d  = (cmd_q.cls == CMD_TEX);
					state_d       = BK_FLUSH;
				end else if (cmd_q.cls == CMD_TEX) begin
					state_d = BK_SEARCH;
				end else begin
					state_d = BK_ACK;
				end
			end
			BK_FLUSH: begin
				if (!fl_nz || out_free) begin
					if (fl_nz) begin
						res_load    = 1'b1;
						res_kind_d  = KIND_DRAW;
						res_prim_d  = flush_idx_q;
						res_cnt_d   = fl_cnt;
						res_slots_d = fl_slots;
						res_last_d  = 1'b0;
						dcalls_d    = dcalls_q + 32'd1;
					end
					flush_idx_d = fl_next;
					if (flush_idx_q == PRIM_LINES) begin
						if (flush_clear_q) begin
							quad_cnt_d   = 14'd0;
							circle_cnt_d = 14'd0;
							line_cnt_d   = 16'd0;
							slot_fill_d  = 6'd1;
						end
						state_d = ret_search_q ? BK_SEARCH : BK_ACK;
					end
				end
			end
			BK_SEARCH: begin
				if (hit) begin
					slot_d  = hit_idx;
					state_d = BK_ACK;
				end else if (slot_fill_q >= slim) begin
					flush_idx_d   = PRIM_QUADS;
					flush_clear_d = 1'b1;
					ret_search_d  = 1'b1;
					state_d       = BK_FLUSH;
				end else begin
					tbl_wr      = 1'b1;
					slot_d      = slot_fill_q[4:0];
					slot_fill_d = slot_fill_q + 6'd1;
					state_d     = BK_ACK;
				end
			end
			BK_ACK: begin
				if (out_free) begin
					case (cmd_q.cls) inside
						CMD_QUAD, CMD_TEX: begin
							quad_cnt_d = quad_cnt_q + 14'd1;
							quads_d    = quads_q + 32'd1;
						end
						CMD_CIRCLE: begin
							circle_cnt_d = circle_cnt_q + 14'd1;
							quads_d      = quads_q + 32'd1;
						end
						CMD_LINE: begin
							line_cnt_d = line_cnt_q + 16'd2;
						end
						CMD_BEGIN: begin
							quad_cnt_d   = 14'd0;
							circle_cnt_d = 14'd0;
							line_cnt_d   = 16'd0;
							slot_fill_d  = 6'd1;
						end
						CMD_RSTAT: begin
							dcalls_d = 32'd0;
							quads_d  = 32'd0;
						end
						default: begin
						end
					endcase
					res_load   = 1'b1;
					res_slot_d = slot_q;
					state_d    = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase

		if (res_load) begin
			res_valid_d = 1'b1;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Batch counters, statistics and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_fill_q   <= 6'd1;
			quad_cnt_q    <= 14'd0;
			circle_cnt_q  <= 14'd0;
			line_cnt_q    <= 16'd0;
			dcalls_q      <= 32'd0;
			quads_q       <= 32'd0;
			res_valid_q   <= 1'b0;
			flush_idx_q   <= PRIM_QUADS;
			flush_clear_q <= 1'b0;
			ret_search_q  <= 1'b0;
		end else begin
			slot_fill_q   <= slot_fill_d;
			quad_cnt_q    <= quad_cnt_d;
			circle_cnt_q  <= circle_cnt_d;
			line_cnt_q    <= line_cnt_d;
			dcalls_q      <= dcalls_d;
			quads_q       <= quads_d;
			res_valid_q   <= res_valid_d;
			flush_idx_q   <= flush_idx_d;
			flush_clear_q <= flush_clear_d;
			ret_search_q  <= ret_search_d;
		end
	end

	// Command, slot table and result payload
	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		slot_q <= slot_d;
		for (int i = 1; i < TEX_SLOTS; i++) begin
			if (tbl_wr && slot_fill_q == 6'(i)) begin
				slot_table_q[i] <= cmd_q.tex;
			end
		end
		if (res_load) begin
			res_kind_q  <= res_kind_d;
			res_prim_q  <= res_prim_d;
			res_cnt_q   <= res_cnt_d;
			res_slots_q <= res_slots_d;
			res_slot_q  <= res_slot_d;
			res_last_q  <= res_last_d;
		end
	end

	// Totals are registered counters, already updated when the result loads
	logic [31:0] tot_dcalls_q;
	logic [31:0] tot_quads_q;
	always_ff @(posedge clk) begin
		if (res_load) begin
			tot_dcalls_q <= dcalls_d;
			tot_quads_q  <= quads_d;
		end
	end

	assign res_valid        = res_valid_q;
	assign kind             = res_kind_q;
	assign primitive_res    = res_prim_q;
	assign draw_count       = res_cnt_q;
	assign slots_in_use     = res_slots_q;
	assign tex_slot         = res_slot_q;
	assign last             = res_last_q;
	assign draw_calls_total = tot_dcalls_q;
	assign quads_total      = tot_quads_q;

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the draw batch texture slot binder: predictor, stimulus, checks.
import dbtsb_pkg::*;

typedef struct packed {
	logic        kind;
	logic [1:0]  prim;
	logic [16:0] count;
	logic [5:0]  slots;
	logic [4:0]  slot;
	logic        last;
	logic [31:0] calls;
	logic [31:0] quads;
} draw_result_t;

// Tracks the batch, the slot bindings and the totals; holds the results still owed.
class draw_call_ledger;
	localparam int QUAD_CAP_MAX = 8192;
	localparam int SLOT_CAP_MAX = 32;

	logic [31:0] bound_tex [32];
	logic [5:0]  slot_fill;
	logic [13:0] batch_quads;
	logic [13:0] batch_circles;
	logic [15:0] batch_line_verts;
	logic [31:0] calls_total;
	logic [31:0] quads_sum;
	logic [13:0] quad_limit;
	logic [5:0]  slot_limit;
	draw_result_t owed_results [$];
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned draws_seen;

	function new();
		foreach (bound_tex[i]) bound_tex[i] = '0;
		quad_limit = QUAD_LIMIT_RST;
		slot_limit = SLOT_LIMIT_RST;
		calls_total = '0;
		quads_sum = '0;
		mismatches = 0;
		results_seen = 0;
		draws_seen = 0;
		clear_batch();
	endfunction

	function void set_limit(logic idx, logic [13:0] val);
		if (idx == REG_QUAD_LIMIT)
			quad_limit = val;
		else
			slot_limit = val[5:0];
	endfunction

	// Saturate the limits the way the block uses them
	function int quad_cap();
		int v;
		v = int'(quad_limit);
		if (v < 1) v = 1;
		if (v > QUAD_CAP_MAX) v = QUAD_CAP_MAX;
		return v;
	endfunction

	function int slot_cap();
		int v;
		v = int'(slot_limit);
		if (v < 2) v = 2;
		if (v > SLOT_CAP_MAX) v = SLOT_CAP_MAX;
		return v;
	endfunction

	function void clear_batch();
		batch_quads = '0;
		batch_circles = '0;
		batch_line_verts = '0;
		slot_fill = 6'd1;
	endfunction

	function void owe(logic kind, logic [1:0] prim, int unsigned count, logic [5:0] slots,
			logic [4:0] slot, logic last);
		draw_result_t r;
		r.kind = kind;
		r.prim = prim;
		r.count = count[16:0];
		r.slots = slots;
		r.slot = slot;
		r.last = last;
		r.calls = calls_total;
		r.quads = quads_sum;
		owed_results.push_back(r);
	endfunction

	// Issue the non-empty draw calls: quads, circles, lines
	function void issue_draws();
		if (batch_quads != 0) begin
			calls_total++;
			owe(KIND_DRAW, PRIM_QUADS, batch_quads * 6, slot_fill, '0, 1'b0);
		end
		if (batch_circles != 0) begin
			calls_total++;
			owe(KIND_DRAW, PRIM_CIRCLES, batch_circles * 6, '0, '0, 1'b0);
		end
		if (batch_line_verts != 0) begin
			calls_total++;
			owe(KIND_DRAW, PRIM_LINES, batch_line_verts, '0, '0, 1'b0);
		end
	endfunction

	function void start_batch();
		issue_draws();
		clear_batch();
	endfunction

	// Work out the results of one accepted command request
	function void take_command(logic [2:0] op, logic [31:0] tex);
		logic [4:0] slot;
		bit found;
		int i;
		slot = '0;
		found = 1'b0;
		case (op) inside
		OP_BEGIN: clear_batch();
		OP_QUAD, OP_TEX: begin
			if (batch_quads >= quad_cap())
				start_batch();
			if (op == OP_TEX) begin
				for (i = 1; i < slot_fill && i < 32; i++) begin
					if (!found && bound_tex[i] == tex) begin
						slot = i[4:0];
						found = 1'b1;
					end
				end
				if (!found) begin
					if (slot_fill >= slot_cap())
						start_batch();
					slot = slot_fill[4:0];
					bound_tex[slot] = tex;
					slot_fill++;
				end
			end
			batch_quads++;
			quads_sum++;
		end
		OP_CIRCLE: begin
			if (batch_circles >= quad_cap())
				start_batch();
			batch_circles++;
			quads_sum++;
		end
		OP_LINE: begin
			if (int'(batch_line_verts) + 2 > quad_cap() * 4)
				start_batch();
			batch_line_verts += 16'd2;
		end
		OP_END: issue_draws();
		OP_RSTAT: begin
			calls_total = '0;
			quads_sum = '0;
		end
		default: ;
		endcase
		owe(KIND_ACK, PRIM_QUADS, 0, '0, slot, 1'b1);
	endfunction

	function string show(draw_result_t r);
		return $sformatf("kind %0d prim %0d count %0d slots %0d slot %0d last %0d calls %0d quads %0d",
			r.kind, r.prim, r.count, r.slots, r.slot, r.last, r.calls, r.quads);
	endfunction

	// Compare one accepted result with the oldest one owed
	function void match_result(draw_result_t got);
		draw_result_t want;
		string bad;
		bad = "";
		want = '0;
		results_seen++;
		if (got.kind == KIND_DRAW) draws_seen++;
		if (owed_results.size() == 0) begin
			bad = " (nothing outstanding)";
		end else begin
			want = owed_results.pop_front();
			if (got.kind !== want.kind) bad = {bad, " kind"};
			if (got.prim !== want.prim) bad = {bad, " primitive_res"};
			if (got.count !== want.count) bad = {bad, " draw_count"};
			if (got.slots !== want.slots) bad = {bad, " slots_in_use"};
			if (got.slot !== want.slot) bad = {bad, " tex_slot"};
			if (got.last !== want.last) bad = {bad, " last"};
			if (got.calls !== want.calls) bad = {bad, " draw_calls_total"};
			if (got.quads !== want.quads) bad = {bad, " quads_total"};
		end
		if (bad != "") begin
			if (mismatches < 10)
				$display("mismatch%s\n  want %s\n  got  %s", bad, show(want), show(got));
			mismatches++;
		end
	endfunction
endclass

module testbench;
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [2:0]  opcode = OP_BEGIN;
	logic [31:0] texture_id = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        kind;
	logic [1:0]  primitive_res;
	logic [16:0] draw_count;
	logic [5:0]  slots_in_use;
	logic [4:0]  tex_slot;
	logic        last;
	logic [31:0] draw_calls_total;
	logic [31:0] quads_total;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	draw_call_ledger ledger = new();
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;
	int unsigned commands_sent = 0;
	int unsigned reg_writes = 0;
	bit gaps_on = 1'b1;
	stall_mode_t stall_mode = STALL_NONE;
	int stall_age = 0;

	// Limit settings for the random scenes, extremes included
	logic [13:0] scene_qlim [8] = '{14'd16383, 14'd2, 14'd1, 14'd0, 14'd3, 14'd8192, 14'd5, 14'd2};
	logic [5:0]  scene_slim [8] = '{6'd63, 6'd3, 6'd5, 6'd0, 6'd2, 6'd1, 6'd5, 6'd32};

	draw_batch_texture_slot_binder_top uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result side on a pattern chosen at random and renewed when its age counter runs out
	always @(posedge clk) begin
		if (stall_age == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_age <= $urandom_range(20, 80);
		end else begin
			stall_age <= stall_age - 1;
		end
		case (stall_mode)
		STALL_NONE:  res_stall <= 1'b0;
		STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
		STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 6);
		default:     res_stall <= ((stall_age % 5) < 3);
		endcase
	end

	// Check every accepted result
	always @(posedge clk) begin : watch_results
		draw_result_t got;
		if (arst_n && res_valid && !res_stall) begin
			got.kind = kind;
			got.prim = primitive_res;
			got.count = draw_count;
			got.slots = slots_in_use;
			got.slot = tex_slot;
			got.last = last;
			got.calls = draw_calls_total;
			got.quads = quads_total;
			ledger.match_result(got);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d results outstanding",
				cycle_count, ledger.owed_results.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Send one command request, opening a new burst after a random gap
	task automatic send_cmd(input logic [2:0] op, input logic [31:0] tex);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_valid <= 1'b1;
		opcode <= op;
		texture_id <= tex;
		do @(posedge clk); while (cmd_stall);
		ledger.take_command(op, tex);
		commands_sent++;
	endtask

	// Drop valid and wait until every owed result is back and the block has settled
	task automatic drain();
		cmd_valid <= 1'b0;
		while (ledger.owed_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		burst_left = 0;
	endtask

	// Write a limit register; unused upper data bits carry junk
	task automatic write_reg(input logic idx, input logic [13:0] val);
		logic [31:0] junk;
		junk = $urandom();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= (idx == REG_QUAD_LIMIT) ? {junk[31:14], val} : {junk[31:6], val[5:0]};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ledger.set_limit(idx, val);
		reg_writes++;
	endtask

	// One scene under new limits: begin, random draw commands with some noise, end
	task automatic run_scene(input logic [13:0] qlim, input logic [5:0] slim);
		logic [31:0] tex_pool [8];
		logic [31:0] tex;
		logic [2:0] op;
		int pool_n;
		int body;
		int pick;
		drain();
		write_reg(REG_QUAD_LIMIT, qlim);
		write_reg(REG_SLOT_LIMIT, 14'(slim));
		gaps_on = ($urandom_range(0, 2) != 0);
		pool_n = $urandom_range(2, 8);
		foreach (tex_pool[i]) tex_pool[i] = $urandom();
		body = $urandom_range(14, 18);
		send_cmd(OP_BEGIN, $urandom());
		repeat (body) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) op = OP_TEX;
			else if (pick < 50) op = OP_QUAD;
			else if (pick < 68) op = OP_CIRCLE;
			else if (pick < 86) op = OP_LINE;
			else if (pick < 91) op = OP_END;
			else if (pick < 94) op = OP_RSTAT;
			else if (pick < 97) op = OP_BEGIN;
			else op = OP_UNUSED;
			tex = ($urandom_range(0, 4) == 0) ? $urandom() : tex_pool[$urandom_range(0, pool_n - 1)];
			send_cmd(op, tex);
		end
		send_cmd(OP_END, $urandom());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default limits: every opcode, texture extremes, slot hit, full flush, double end
		send_cmd(OP_BEGIN, 32'h0);
		send_cmd(OP_QUAD, 32'hFFFF_FFFF);
		send_cmd(OP_TEX, 32'h0);
		send_cmd(OP_TEX, 32'hFFFF_FFFF);
		send_cmd(OP_TEX, 32'h0);
		send_cmd(OP_CIRCLE, 32'h0);
		send_cmd(OP_LINE, 32'h0);
		send_cmd(OP_END, 32'h0);
		send_cmd(OP_END, 32'h0);
		send_cmd(OP_UNUSED, 32'h0);
		send_cmd(OP_RSTAT, 32'h0);
		send_cmd(OP_BEGIN, 32'h0);

		// One usable slot: a new texture forces a flush with all three primitives pending
		drain();
		write_reg(REG_SLOT_LIMIT, 14'd2);
		send_cmd(OP_TEX, 32'h5);
		send_cmd(OP_TEX, 32'h5);
		send_cmd(OP_TEX, 32'h6);
		send_cmd(OP_CIRCLE, 32'h0);
		send_cmd(OP_LINE, 32'h0);
		send_cmd(OP_TEX, 32'h7);

		// Quad limit lowered mid-batch, then circle and line overflow
		drain();
		write_reg(REG_QUAD_LIMIT, 14'd1);
		write_reg(REG_SLOT_LIMIT, 14'd32);
		send_cmd(OP_QUAD, 32'h0);
		send_cmd(OP_CIRCLE, 32'h0);
		send_cmd(OP_CIRCLE, 32'h0);
		send_cmd(OP_LINE, 32'h0);
		send_cmd(OP_LINE, 32'h0);
		send_cmd(OP_LINE, 32'h0);
		send_cmd(OP_END, 32'h0);

		foreach (scene_qlim[i])
			run_scene(scene_qlim[i], scene_slim[i]);
		drain();

		$display("%0d commands sent across %0d register writes", commands_sent, reg_writes);
		$display("%0d results checked, %0d of them draw calls, %0d mismatches",
			ledger.results_seen, ledger.draws_seen, ledger.mismatches);
		if (ledger.mismatches == 0 && ledger.owed_results.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
